>>> hw/rtl/scc_pkg.sv
// Shared types, register indexes and constants of the stick centre/span calibrator.
// No dependencies; every other file but scc_checker imports this package.
package scc_pkg;

   localparam int RAW_W      = 12;
   localparam int OFF_W      = RAW_W + 1;
   localparam int OUT_W      = 16;
   localparam int DIV_STEPS  = RAW_W + 15;
   localparam int CNT_W      = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W  = 3;

   localparam logic [DIV_STEPS-1:0] AXIS_FULL     = DIV_STEPS'(32767);
   localparam logic [DIV_STEPS-1:0] AXIS_FULL_NEG = DIV_STEPS'(32768);
   localparam logic [OUT_W-1:0]     OUT_MAX       = 16'sh7FFF;
   localparam logic [3:0]           NIBBLE_MASK   = 4'hF;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type REG_CENTER_X    = 3'd0;
   localparam csr_index_type REG_CENTER_Y    = 3'd1;
   localparam csr_index_type REG_REACH_RIGHT = 3'd2;
   localparam csr_index_type REG_REACH_UP    = 3'd3;
   localparam csr_index_type REG_REACH_LEFT  = 3'd4;
   localparam csr_index_type REG_REACH_DOWN  = 3'd5;

   localparam logic [RAW_W-1:0] CENTER_RESET = 12'd2048;
   localparam logic [RAW_W-1:0] REACH_RESET  = 12'd2047;

   typedef struct packed {
      logic [RAW_W-1:0] center_x;
      logic [RAW_W-1:0] center_y;
      logic [RAW_W-1:0] reach_right;
      logic [RAW_W-1:0] reach_up;
      logic [RAW_W-1:0] reach_left;
      logic [RAW_W-1:0] reach_down;
   } cal_cfg_type;

   typedef struct packed {
      logic [RAW_W-1:0] mag;
      logic             off_neg;
      logic [RAW_W-1:0] reach;
   } axis_job_type;

   typedef struct packed {
      axis_job_type x;
      axis_job_type y;
      logic         x_changed;
      logic         y_changed;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_DIV  = 3'b010,
      BK_OUT  = 3'b100
   } back_state_type;

   function automatic logic [DIV_STEPS-1:0] scaled_dividend(input logic [RAW_W-1:0] mag);
      logic [DIV_STEPS-1:0] wide;
      wide = DIV_STEPS'(mag);
      return (wide << 15) - wide;
   endfunction

   function automatic logic [OUT_W-1:0] scale_finish(input logic [DIV_STEPS-1:0] quo,
                                                    input axis_job_type   job,
                                                    input logic           neg_out);
      logic [DIV_STEPS-1:0] q;
      logic [DIV_STEPS-1:0] cap;
      logic [OUT_W-1:0]     res;
      cap = job.off_neg ? AXIS_FULL_NEG : AXIS_FULL;
      q   = quo;
      if (job.reach == '0)
         q = (job.mag == '0) ? '0 : cap;
      else if (q > cap)
         q = cap;
      if (neg_out)
         res = OUT_W'(16'd0 - q[OUT_W-1:0]);
      else if (q >= AXIS_FULL)
         res = OUT_MAX;
      else
         res = q[OUT_W-1:0];
      return res;
   endfunction

endpackage

>>> hw/rtl/scc_if.sv
// Handshake channels of the stick centre/span calibrator: report, result, register write.
// Depends on scc_pkg.
interface scc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_lo;
   logic [7:0] byte_mid;
   logic [7:0] byte_hi;
   modport source (output valid, byte_lo, byte_mid, byte_hi, input ready);
   modport sink   (input valid, byte_lo, byte_mid, byte_hi, output ready);
endinterface

interface scc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] x_out;
   logic signed [15:0] y_out;
   logic               x_changed;
   logic               y_changed;
   modport source (output valid, x_out, y_out, x_changed, y_changed, input ready);
   modport sink   (input valid, x_out, y_out, x_changed, y_changed, output ready);
endinterface

interface scc_csr_if import scc_pkg::*;;
   logic             valid;
   logic             ready;
   csr_index_type    index;
   logic [RAW_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/scc_front.sv
// Front end: unpacks the report bytes, tracks last raw values and forms one job per report, one part per axis.
// Depends on scc_pkg and scc_if.
module scc_front import scc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   scc_req_if.sink       req,
   input  cal_cfg_type   cfg,
   input  logic          q_full,
   output logic          q_push,
   output job_type       q_job
);

   logic [RAW_W-1:0] last_x_ff, last_x_in;
   logic [RAW_W-1:0] last_y_ff, last_y_in;
   logic [RAW_W-1:0] raw_x;
   logic [RAW_W-1:0] raw_y;

   function automatic axis_job_type make_axis(input logic [RAW_W-1:0] raw,
                                              input logic [RAW_W-1:0] centre,
                                              input logic [RAW_W-1:0] reach_pos,
                                              input logic [RAW_W-1:0] reach_neg);
      logic [OFF_W-1:0] off;
      logic [OFF_W-1:0] mag;
      axis_job_type     job;
      off         = {1'b0, raw} - {1'b0, centre};
      mag         = off[OFF_W-1] ? (OFF_W'(0) - off) : off;
      job.off_neg = off[OFF_W-1];
      job.mag     = mag[RAW_W-1:0];
      job.reach   = off[OFF_W-1] ? reach_neg : reach_pos;
      return job;
   endfunction

   assign raw_x     = {req.byte_mid[3:0] & NIBBLE_MASK, req.byte_lo};
   assign raw_y     = {req.byte_hi, req.byte_mid[7:4]};
   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      q_job.x         = make_axis(raw_x, cfg.center_x, cfg.reach_right, cfg.reach_left);
      q_job.y         = make_axis(raw_y, cfg.center_y, cfg.reach_up, cfg.reach_down);
      q_job.x_changed = raw_x != last_x_ff;
      q_job.y_changed = raw_y != last_y_ff;
      last_x_in       = q_push ? raw_x : last_x_ff;
      last_y_in       = q_push ? raw_y : last_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= '0;
         last_y_ff <= '0;
      end else begin
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
      end
   end

endmodule

>>> hw/rtl/scc_queue.sv
// Short job queue between the front end and the divider back end.
// Depends on scc_pkg.
module scc_queue import scc_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    empty,
   output logic    full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type             mem [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign empty = count_ff == '0;
   assign full  = count_ff == CNT_W'(DEPTH);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         mem[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/scc_back.sv
// Back end: shared restoring divider over both axes, saturation and the result register.
// Depends on scc_pkg and scc_if.
module scc_back import scc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  job_type head,
   input  logic    q_empty,
   output logic    q_pop,
   scc_rsp_if.source rsp
);

   back_state_type       state_ff, state_in;
   logic                 axis_ff, axis_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [RAW_W-1:0]     rem_ff, rem_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;
   logic [OUT_W-1:0]     x_res_ff, x_res_in;
   logic [OUT_W-1:0]     y_res_ff, y_res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]     rsp_x_ff, rsp_x_in;
   logic [OUT_W-1:0]     rsp_y_ff, rsp_y_in;
   logic                 rsp_xc_ff, rsp_xc_in;
   logic                 rsp_yc_ff, rsp_yc_in;
   axis_job_type         cur;
   logic [RAW_W:0]       trial;
   logic                 ge;
   logic [RAW_W:0]       diff;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.x_out     = rsp_x_ff;
   assign rsp.y_out     = rsp_y_ff;
   assign rsp.x_changed = rsp_xc_ff;
   assign rsp.y_changed = rsp_yc_ff;

   always_comb begin
      cur          = axis_ff ? head.y : head.x;
      trial        = {rem_ff, quo_ff[DIV_STEPS-1]};
      ge           = trial >= {1'b0, cur.reach};
      diff         = trial - {1'b0, cur.reach};
      state_in     = state_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      x_res_in     = x_res_ff;
      y_res_in     = y_res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_xc_in    = rsp_xc_ff;
      rsp_yc_in    = rsp_yc_ff;
      q_pop        = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               axis_in  = 1'b0;
               cnt_in   = '0;
               rem_in   = '0;
               quo_in   = scaled_dividend(head.x.mag);
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            rem_in = ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
            quo_in = {quo_ff[DIV_STEPS-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               if (!axis_ff) begin
                  x_res_in = scale_finish(quo_in, cur, cur.off_neg);
                  axis_in  = 1'b1;
                  cnt_in   = '0;
                  rem_in   = '0;
                  quo_in   = scaled_dividend(head.y.mag);
               end else begin
                  y_res_in = scale_finish(quo_in, cur, !cur.off_neg);
                  state_in = BK_OUT;
               end
            end
         end
         BK_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_res_ff;
               rsp_y_in     = y_res_ff;
               rsp_xc_in    = head.x_changed;
               rsp_yc_in    = head.y_changed;
               q_pop        = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      axis_ff  <= axis_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      x_res_ff <= x_res_in;
      y_res_ff <= y_res_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_xc_ff <= rsp_xc_in;
      rsp_yc_ff <= rsp_yc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/stick_center_span_calibrator_unit.sv
// Stick centre/span calibrator: one report beat of three packed bytes in, one beat of two
// calibrated 16-bit axes and two changed flags out. The front end unpacks and classifies a
// report in the cycle it is taken and places it in a short queue; a single restoring divider,
// one quotient bit per cycle, then serves X and then Y. A report passes the idle state, the
// X division, the Y division and the output state, and the divider takes the next report only
// once that one has been handed to the output register. The queue holds up to QUEUE_DEPTH
// reports, the one in the divider included; a finished result waits in the output register
// while the divider works on the next one, whose hand-off waits until the register is free.
// Register writes are taken in any cycle (csr ready is always high); indexes beyond five are
// dropped and take effect on reports accepted afterwards.
module stick_center_span_calibrator_unit import scc_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   scc_req_if.sink   req,
   scc_rsp_if.source rsp,
   scc_csr_if.sink   csr
);

   cal_cfg_type cfg_ff, cfg_in;
   logic        q_push;
   logic        q_pop;
   logic        q_empty;
   logic        q_full;
   job_type     q_job;
   job_type     q_head;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_CENTER_X:    cfg_in.center_x    = csr.data;
            REG_CENTER_Y:    cfg_in.center_y    = csr.data;
            REG_REACH_RIGHT: cfg_in.reach_right = csr.data;
            REG_REACH_UP:    cfg_in.reach_up    = csr.data;
            REG_REACH_LEFT:  cfg_in.reach_left  = csr.data;
            REG_REACH_DOWN:  cfg_in.reach_down  = csr.data;
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x    <= CENTER_RESET;
         cfg_ff.center_y    <= CENTER_RESET;
         cfg_ff.reach_right <= REACH_RESET;
         cfg_ff.reach_up    <= REACH_RESET;
         cfg_ff.reach_left  <= REACH_RESET;
         cfg_ff.reach_down  <= REACH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (q_job)
   );

   scc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   scc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (q_head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

>>> hw/rtl/scc_checker.sv
// Port-level checks of the stick centre/span calibrator, bound to the top level.
// Depends on stick_center_span_calibrator_unit.
module scc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_x_out,
   input logic [15:0] rsp_y_out
);

   logic [7:0] pending_ff, pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + (req_beat ? 8'd1 : 8'd0) - (rsp_beat ? 8'd1 : 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset)
         pending_ff <= '0;
      else
         pending_ff <= pending_in;
   end

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_x_out) && $stable(rsp_y_out))
      else $error("result payload changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("result beat without an accepted report");

   a_no_bypass: assert property (@(posedge clock) disable iff (reset)
      req_beat && pending_ff == 8'd0 |=> !rsp_valid)
      else $error("result appeared before the divider could finish");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stick_center_span_calibrator_unit scc_checker u_scc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_x_out (rsp.x_out),
   .rsp_y_out (rsp.y_out)
);

>>> verif/tb_top.sv
// Testbench of the stick centre/span calibrator: a directed table, then random calibration
// phases with bursty reports and receiver stalls; results checked against table or predictor.
// Depends on scc_pkg, the scc_*_if channels and stick_center_span_calibrator_unit.
module tb_top import scc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FULL_SCALE    = 32767;
   localparam int OUT_HIGH      = 32767;
   localparam int OUT_LOW       = -32768;
   localparam int RAW_MAX       = 4095;
   localparam int PHASES        = 8;
   localparam int PHASE_REPORTS = 106;
   localparam int LONG_HOLD     = 600;
   localparam int HOLD_AFTER    = 250;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int STEP_COUNT    = 36;

   localparam csr_index_type IDX_SPARE_LO = 3'd6;
   localparam csr_index_type IDX_SPARE_HI = 3'd7;

   typedef struct packed {
      logic signed [15:0] x_out;
      logic signed [15:0] y_out;
      logic               x_changed;
      logic               y_changed;
   } stick_result_type;

   typedef enum {STEP_REPORT, STEP_KNOWN, STEP_WRITE} step_kind_type;

   typedef struct {
      step_kind_type    kind;
      csr_index_type    index;
      logic [RAW_W-1:0] data;
      logic [7:0]       lo;
      logic [7:0]       mid;
      logic [7:0]       hi;
      int               x;
      int               y;
      bit               xc;
      bit               yc;
   } step_type;

   step_type directed_steps [STEP_COUNT] = '{
      '{STEP_KNOWN,  REG_CENTER_X,    12'h000, 8'h00, 8'h00, 8'h00, -32768, 32767, 1'b0, 1'b0},
      '{STEP_KNOWN,  REG_CENTER_X,    12'h000, 8'hFF, 8'hFF, 8'hFF, 32767, -32767, 1'b1, 1'b1},
      '{STEP_KNOWN,  REG_CENTER_X,    12'h000, 8'h00, 8'h08, 8'h80, 0, 0, 1'b1, 1'b1},
      '{STEP_KNOWN,  REG_CENTER_X,    12'h000, 8'h00, 8'h08, 8'h80, 0, 0, 1'b0, 1'b0},
      '{STEP_REPORT, REG_CENTER_X,    12'h000, 8'h01, 8'h08, 8'h80, 0, 0, 1'b0, 1'b0},
      '{STEP_REPORT, REG_CENTER_X,    12'h000, 8'hFF, 8'h07, 8'h80, 0, 0, 1'b0, 1'b0},
      '{STEP_REPORT, REG_CENTER_X,    12'h000, 8'h00, 8'h18, 8'h80, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_REACH_RIGHT, 12'h000, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_REACH_UP,    12'h000, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_REACH_LEFT,  12'h000, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_REACH_DOWN,  12'h000, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_KNOWN,  REG_CENTER_X,    12'h000, 8'hFF, 8'hFF, 8'hFF, 32767, -32767, 1'b1, 1'b1},
      '{STEP_KNOWN,  REG_CENTER_X,    12'h000, 8'h00, 8'h00, 8'h00, -32768, 32767, 1'b1, 1'b1},
      '{STEP_KNOWN,  REG_CENTER_X,    12'h000, 8'h00, 8'h08, 8'h80, 0, 0, 1'b1, 1'b1},
      '{STEP_WRITE,  IDX_SPARE_LO,    12'hFFF, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  IDX_SPARE_HI,    12'hFFF, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_KNOWN,  REG_CENTER_X,    12'h000, 8'h00, 8'h08, 8'h80, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_CENTER_X,    12'h000, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_CENTER_Y,    12'hFFF, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_REACH_RIGHT, 12'hFFF, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_REACH_UP,    12'h001, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_REACH_LEFT,  12'h001, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_REACH_DOWN,  12'hFFF, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_KNOWN,  REG_CENTER_X,    12'h000, 8'hFF, 8'hFF, 8'hFF, 32767, 0, 1'b1, 1'b1},
      '{STEP_KNOWN,  REG_CENTER_X,    12'h000, 8'h00, 8'h00, 8'h00, 0, 32767, 1'b1, 1'b1},
      '{STEP_REPORT, REG_CENTER_X,    12'h000, 8'h01, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_REPORT, REG_CENTER_X,    12'h000, 8'h00, 8'h10, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_CENTER_X,    12'hFFF, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_CENTER_Y,    12'h000, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_REACH_LEFT,  12'hFFF, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_KNOWN,  REG_CENTER_X,    12'h000, 8'h00, 8'h00, 8'h00, -32767, 0, 1'b0, 1'b1},
      '{STEP_KNOWN,  REG_CENTER_X,    12'h000, 8'hFF, 8'hFF, 8'hFF, 0, -32767, 1'b1, 1'b1},
      '{STEP_REPORT, REG_CENTER_X,    12'h000, 8'hFE, 8'hFF, 8'hFF, 0, 0, 1'b0, 1'b0},
      '{STEP_REPORT, REG_CENTER_X,    12'h000, 8'hFF, 8'h0F, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_WRITE,  REG_REACH_LEFT,  12'h001, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0},
      '{STEP_REPORT, REG_CENTER_X,    12'h000, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0}
   };

   csr_index_type reg_order [6] = '{REG_CENTER_X, REG_CENTER_Y, REG_REACH_RIGHT,
                                    REG_REACH_UP, REG_REACH_LEFT, REG_REACH_DOWN};

   logic clock;
   logic reset;

   scc_req_if req_ch ();
   scc_rsp_if rsp_ch ();
   scc_csr_if csr_ch ();

   cal_cfg_type      cal;
   logic [RAW_W-1:0] last_x_raw;
   logic [RAW_W-1:0] last_y_raw;
   stick_result_type awaited_results [$];
   stick_result_type head_result;
   int               mismatch_count;
   int               results_seen;
   int               cycle_count;

   stick_center_span_calibrator_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   function automatic int clamp16(int v);
      if (v > OUT_HIGH) return OUT_HIGH;
      if (v < OUT_LOW) return OUT_LOW;
      return v;
   endfunction

   function automatic int scale_offset(int off, int reach_pos, int reach_neg);
      int reach;
      reach = (off < 0) ? reach_neg : reach_pos;
      if (reach == 0) begin
         if (off > 0) return OUT_HIGH;
         if (off < 0) return OUT_LOW;
         return 0;
      end
      return clamp16((off * FULL_SCALE) / reach);
   endfunction

   // advance the per-axis history along with the prediction
   function automatic stick_result_type calibrate_report(logic [7:0] lo, logic [7:0] mid,
                                                        logic [7:0] hi);
      logic [RAW_W-1:0] rx;
      logic [RAW_W-1:0] ry;
      stick_result_type r;
      rx = {mid[3:0], lo};
      ry = {hi, mid[7:4]};
      r.x_out = 16'(scale_offset(int'(rx) - int'(cal.center_x),
                                 int'(cal.reach_right), int'(cal.reach_left)));
      r.y_out = 16'(clamp16(-scale_offset(int'(ry) - int'(cal.center_y),
                                          int'(cal.reach_up), int'(cal.reach_down))));
      r.x_changed = (rx != last_x_raw);
      r.y_changed = (ry != last_y_raw);
      last_x_raw = rx;
      last_y_raw = ry;
      return r;
   endfunction

   function automatic logic [RAW_W-1:0] near_raw(logic [RAW_W-1:0] centre);
      int span;
      int v;
      case ($urandom_range(0, 2))
         0: span = 3;
         1: span = 40;
         default: span = 2200;
      endcase
      v = int'(centre) + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > RAW_MAX) v = RAW_MAX;
      return RAW_W'(v);
   endfunction

   function automatic logic [RAW_W-1:0] pick_setting(bit is_centre, int phase);
      if (phase == 0) return 12'hFFF;
      if (phase == 1) return 12'h000;
      case ($urandom_range(0, 9))
         0: return 12'h000;
         1: return 12'hFFF;
         2: return RAW_W'($urandom_range(0, RAW_MAX));
         3: return RAW_W'($urandom_range(1, 3));
         default: return is_centre ? RAW_W'($urandom_range(1700, 2400))
                                   : RAW_W'($urandom_range(1200, 2100));
      endcase
   endfunction

   task automatic hold_reports(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
   endtask

   task automatic send_report(logic [7:0] lo, logic [7:0] mid, logic [7:0] hi,
                              bit known, stick_result_type known_result);
      stick_result_type r;
      @(negedge clock);
      req_ch.valid    <= 1'b1;
      req_ch.byte_lo  <= lo;
      req_ch.byte_mid <= mid;
      req_ch.byte_hi  <= hi;
      do @(posedge clock); while (!req_ch.ready);
      r = calibrate_report(lo, mid, hi);
      awaited_results.push_back(known ? known_result : r);
   endtask

   task automatic drain_results();
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [RAW_W-1:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_CENTER_X:    cal.center_x    = val;
         REG_CENTER_Y:    cal.center_y    = val;
         REG_REACH_RIGHT: cal.reach_right = val;
         REG_REACH_UP:    cal.reach_up    = val;
         REG_REACH_LEFT:  cal.reach_left  = val;
         REG_REACH_DOWN:  cal.reach_down  = val;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_random_report();
      logic [RAW_W-1:0] rx;
      logic [RAW_W-1:0] ry;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            rx = near_raw(cal.center_x);
            ry = near_raw(cal.center_y);
         end
         5, 6: begin
            rx = RAW_W'($urandom_range(0, RAW_MAX));
            ry = RAW_W'($urandom_range(0, RAW_MAX));
         end
         7: begin
            rx = last_x_raw;
            ry = last_y_raw;
         end
         8: begin
            rx = last_x_raw;
            ry = near_raw(cal.center_y);
         end
         default: begin
            rx = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            ry = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
         end
      endcase
      send_report(rx[7:0], {ry[3:0], rx[11:8]}, ry[11:4], 1'b0, '0);
   endtask

   task automatic check_field(string what, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (awaited_results.size() == 0) begin
            $display("%0t: result beat with none pending, x_out %0d, y_out %0d", $time,
                     rsp_ch.x_out, rsp_ch.y_out);
            mismatch_count++;
         end else begin
            head_result = awaited_results.pop_front();
            check_field("x_out", int'($signed(head_result.x_out)), int'($signed(rsp_ch.x_out)));
            check_field("y_out", int'($signed(head_result.y_out)), int'($signed(rsp_ch.y_out)));
            check_field("x_changed", int'(head_result.x_changed), int'(rsp_ch.x_changed));
            check_field("y_changed", int'(head_result.y_changed), int'(rsp_ch.y_changed));
         end
      end
   end

   // receiver: stall pattern of its own, one long hold-off once traffic is flowing
   initial begin
      int mode;
      int span;
      bit held_long;
      held_long    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         if (!held_long && results_seen >= HOLD_AFTER) begin
            held_long = 1'b1;
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_ch.ready <= 1'b0;
            end
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            repeat (span) begin
               @(negedge clock);
               case (mode)
                  0: rsp_ch.ready <= 1'b1;
                  1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                  2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
               endcase
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: cycle limit reached", $time);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      stick_result_type known;
      int               burst_left;
      int               gap;
      req_ch.valid    = 1'b0;
      req_ch.byte_lo  = '0;
      req_ch.byte_mid = '0;
      req_ch.byte_hi  = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = REG_CENTER_X;
      csr_ch.data     = '0;
      reset           = 1'b1;
      mismatch_count  = 0;
      results_seen    = 0;
      cal = '{CENTER_RESET, CENTER_RESET, REACH_RESET, REACH_RESET, REACH_RESET, REACH_RESET};
      last_x_raw = '0;
      last_y_raw = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_WRITE) begin
            hold_reports(1);
            drain_results();
            write_reg(directed_steps[i].index, directed_steps[i].data);
         end else begin
            known.x_out     = 16'(directed_steps[i].x);
            known.y_out     = 16'(directed_steps[i].y);
            known.x_changed = directed_steps[i].xc;
            known.y_changed = directed_steps[i].yc;
            send_report(directed_steps[i].lo, directed_steps[i].mid, directed_steps[i].hi,
                        directed_steps[i].kind == STEP_KNOWN, known);
         end
      end

      burst_left = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         hold_reports(1);
         drain_results();
         foreach (reg_order[k])
            write_reg(reg_order[k], pick_setting(reg_order[k] == REG_CENTER_X ||
                                                 reg_order[k] == REG_CENTER_Y, phase));
         if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI,
                      RAW_W'($urandom_range(0, RAW_MAX)));
         for (int n = 0; n < PHASE_REPORTS; n++) begin
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
               hold_reports(gap);
               burst_left = $urandom_range(1, 16);
            end
            send_random_report();
            burst_left--;
         end
      end

      hold_reports(1);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/scc_pkg.sv
hw/rtl/scc_if.sv
hw/rtl/scc_front.sv
hw/rtl/scc_queue.sv
hw/rtl/scc_back.sv
hw/rtl/stick_center_span_calibrator_unit.sv
hw/rtl/scc_checker.sv
verif/tb_top.sv
